/* rtl/apu_frame_sequencer_length_counters_defines.svh */
// Assertion macros shared by the frame sequencer RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef APU_FRAME_SEQUENCER_LENGTH_COUNTERS_DEFINES_SVH
`define APU_FRAME_SEQUENCER_LENGTH_COUNTERS_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define APUFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define APUFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define APUFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define APUFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/apufs_pkg.sv */
// Package for the frame sequencer: item kinds, register offsets, event counts
// and the length load table. Depends on nothing.
package apufs_pkg;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } t_item_mode;

    localparam int unsigned CNT_W = 16;
    localparam int unsigned LEN_W = 8;
    localparam int unsigned NUM_CH = 4;

    // Register offsets
    localparam logic [4:0] REG_PULSE1_CTRL = 5'h00;
    localparam logic [4:0] REG_PULSE1_LEN  = 5'h03;
    localparam logic [4:0] REG_PULSE2_CTRL = 5'h04;
    localparam logic [4:0] REG_PULSE2_LEN  = 5'h07;
    localparam logic [4:0] REG_TRI_CTRL    = 5'h08;
    localparam logic [4:0] REG_TRI_LEN     = 5'h0B;
    localparam logic [4:0] REG_NOISE_CTRL  = 5'h0C;
    localparam logic [4:0] REG_NOISE_LEN   = 5'h0F;
    localparam logic [4:0] REG_ENABLE      = 5'h15;
    localparam logic [4:0] REG_FRAME       = 5'h17;

    // Written-data bits
    localparam int unsigned HALT_BIT     = 5;
    localparam int unsigned TRI_HALT_BIT = 7;
    localparam int unsigned MODE_BIT     = 7;
    localparam int unsigned INHIBIT_BIT  = 6;
    localparam int unsigned IRQ_RD_BIT   = 6;

    // Sequencer event counts, taken after the increment
    localparam logic [CNT_W-1:0] CYC_Q1      = 16'd7457;
    localparam logic [CNT_W-1:0] CYC_H1      = 16'd14913;
    localparam logic [CNT_W-1:0] CYC_Q3      = 16'd22371;
    localparam logic [CNT_W-1:0] CYC_IRQ_A   = 16'd29831;
    localparam logic [CNT_W-1:0] CYC_H2      = 16'd29832;
    localparam logic [CNT_W-1:0] CYC_IRQ_C   = 16'd29833;
    localparam logic [CNT_W-1:0] CYC_H5      = 16'd37281;
    localparam logic [CNT_W-1:0] PERIOD_FOUR = 16'd29833;
    localparam logic [CNT_W-1:0] PERIOD_FIVE = 16'd37282;

    // Length load table, indexed by the upper five bits of the written byte.
    function automatic logic [LEN_W-1:0] len_lookup(input logic [4:0] idx);
        logic [LEN_W-1:0] v;
        case (idx)
            5'd0:  v = 8'd10;   5'd1:  v = 8'd254;  5'd2:  v = 8'd20;   5'd3:  v = 8'd2;
            5'd4:  v = 8'd40;   5'd5:  v = 8'd4;    5'd6:  v = 8'd80;   5'd7:  v = 8'd6;
            5'd8:  v = 8'd160;  5'd9:  v = 8'd8;    5'd10: v = 8'd60;   5'd11: v = 8'd10;
            5'd12: v = 8'd14;   5'd13: v = 8'd12;   5'd14: v = 8'd26;   5'd15: v = 8'd14;
            5'd16: v = 8'd12;   5'd17: v = 8'd16;   5'd18: v = 8'd24;   5'd19: v = 8'd18;
            5'd20: v = 8'd48;   5'd21: v = 8'd20;   5'd22: v = 8'd96;   5'd23: v = 8'd22;
            5'd24: v = 8'd192;  5'd25: v = 8'd24;   5'd26: v = 8'd72;   5'd27: v = 8'd26;
            5'd28: v = 8'd16;   5'd29: v = 8'd28;   5'd30: v = 8'd32;   5'd31: v = 8'd30;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/apu_frame_sequencer_length_counters.sv */
// Frame sequencer with four length counters; uses apufs_pkg and the defines header.
// A request passes through the input register, then the result register, before its
// result reaches the master side. Throughput: one request per cycle, sustained for
// as long as the master side takes results.
// Reset: synchronous, active low; clears the sequencer count, mode, interrupt,
// length counters, halt and enable flags and both valid bits.
`include "apu_frame_sequencer_length_counters_defines.svh"

module apu_frame_sequencer_length_counters
    import apufs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: [4:0] reg_offset, [12:5] write_data, [15:13] zero
    input  logic [15:0] i_s_axis_tdata,
    // tuser: [1:0] mode (tick, register write, status read)
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: [7:0] read_data, [8] quarter_frame, [9] half_frame, [10] frame_irq,
    // [15:11] zero
    output logic [15:0] o_m_axis_tdata
);

    // Pipeline control. A request sits in the input register until the
    // result register can take its result; the state update happens in that
    // same cycle, so each request changes the state exactly once.
    logic             r_in_valid;
    logic [1:0]       r_in_mode;
    logic [4:0]       r_in_reg;
    logic [7:0]       r_in_data;
    logic             r_out_valid;
    logic [15:0]      r_out_data;
    logic             w_out_free;
    logic             w_proc;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_proc          = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_mode <= i_s_axis_tuser;
            r_in_reg  <= i_s_axis_tdata[4:0];
            r_in_data <= i_s_axis_tdata[12:5];
        end
    end

    // Sequencer and channel state.
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             r_five, n_five;
    logic             r_inh,  n_inh;
    logic             r_irq,  n_irq;
    logic [LEN_W-1:0] r_len [NUM_CH];
    logic [LEN_W-1:0] n_len [NUM_CH];
    logic [NUM_CH-1:0] r_halt, n_halt;
    logic [NUM_CH-1:0] r_en,   n_en;

    // Result of the request being processed.
    logic [7:0]       w_rd;
    logic             w_qf;
    logic             w_hf;
    logic             w_step;

    logic [CNT_W-1:0] w_inc;
    logic [CNT_W-1:0] w_period;
    logic             w_irq_ok;

    assign w_inc    = r_cnt + 16'd1;
    assign w_period = r_five ? PERIOD_FIVE : PERIOD_FOUR;
    assign w_irq_ok = !r_five && !r_inh;

    always_comb begin
        n_cnt  = r_cnt;
        n_five = r_five;
        n_inh  = r_inh;
        n_irq  = r_irq;
        n_halt = r_halt;
        n_en   = r_en;
        w_rd   = 8'd0;
        w_qf   = 1'b0;
        w_hf   = 1'b0;
        w_step = 1'b0;

        case (r_in_mode)
            MODE_TICK: begin
                // Events are decoded on the incremented count, which then
                // wraps at the period of the current mode.
                if (w_inc == CYC_Q1 || w_inc == CYC_Q3) begin
                    w_qf = 1'b1;
                end else if (w_inc == CYC_H1) begin
                    w_qf   = 1'b1;
                    w_hf   = 1'b1;
                    w_step = 1'b1;
                end else if (w_inc == CYC_IRQ_A || w_inc == CYC_IRQ_C) begin
                    if (w_irq_ok) begin
                        n_irq = 1'b1;
                    end
                end else if (w_inc == CYC_H2) begin
                    if (!r_five) begin
                        w_qf   = 1'b1;
                        w_hf   = 1'b1;
                        w_step = 1'b1;
                    end
                    if (w_irq_ok) begin
                        n_irq = 1'b1;
                    end
                end else if (w_inc == CYC_H5) begin
                    if (r_five) begin
                        w_qf   = 1'b1;
                        w_hf   = 1'b1;
                        w_step = 1'b1;
                    end
                end
                // The count never passes the period, so one subtract is a full wrap.
                n_cnt = (w_inc >= w_period) ? (w_inc - w_period) : w_inc;
            end
            MODE_WRITE: begin
                case (r_in_reg)
                    REG_PULSE1_CTRL: n_halt[0] = r_in_data[HALT_BIT];
                    REG_PULSE2_CTRL: n_halt[1] = r_in_data[HALT_BIT];
                    REG_TRI_CTRL:    n_halt[2] = r_in_data[TRI_HALT_BIT];
                    REG_NOISE_CTRL:  n_halt[3] = r_in_data[HALT_BIT];
                    REG_ENABLE:      n_en      = r_in_data[NUM_CH-1:0];
                    REG_FRAME: begin
                        n_five = r_in_data[MODE_BIT];
                        n_inh  = r_in_data[INHIBIT_BIT];
                        if (r_in_data[INHIBIT_BIT]) begin
                            n_irq = 1'b0;
                        end
                        n_cnt = '0;
                        // Writing the frame register with five-step mode set clocks a step at once.
                        if (r_in_data[MODE_BIT]) begin
                            w_qf   = 1'b1;
                            w_hf   = 1'b1;
                            w_step = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            MODE_READ: begin
                // Status shows the interrupt as it stood before the read.
                w_rd[IRQ_RD_BIT] = r_irq;
                for (int i = 0; i < NUM_CH; i++) begin
                    w_rd[i] = (r_len[i] != '0);
                end
                n_irq = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Length counters: load, clear on disable, or step down when not halted.
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            n_len[i] = r_len[i];
            if (w_step && r_len[i] != '0 && !r_halt[i]) begin
                n_len[i] = r_len[i] - 8'd1;
            end
        end
        if (r_in_mode == MODE_WRITE) begin
            case (r_in_reg)
                REG_PULSE1_LEN: if (r_en[0]) n_len[0] = len_lookup(r_in_data[7:3]);
                REG_PULSE2_LEN: if (r_en[1]) n_len[1] = len_lookup(r_in_data[7:3]);
                REG_TRI_LEN:    if (r_en[2]) n_len[2] = len_lookup(r_in_data[7:3]);
                REG_NOISE_LEN:  if (r_en[3]) n_len[3] = len_lookup(r_in_data[7:3]);
                REG_ENABLE: begin
                    for (int i = 0; i < NUM_CH; i++) begin
                        if (!r_in_data[i]) begin
                            n_len[i] = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_five <= 1'b0;
            r_inh  <= 1'b0;
            r_irq  <= 1'b0;
            r_halt <= '0;
            r_en   <= '0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_len[i] <= '0;
            end
        end else if (w_proc) begin
            r_cnt  <= n_cnt;
            r_five <= n_five;
            r_inh  <= n_inh;
            r_irq  <= n_irq;
            r_halt <= n_halt;
            r_en   <= n_en;
            for (int i = 0; i < NUM_CH; i++) begin
                r_len[i] <= n_len[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_data <= {5'd0, n_irq, w_hf, w_qf, w_rd};
        end
    end

    // The count stays below the period of the current mode.
    `APUFS_ASSERT_NOW(a_cnt_in_period, i_clk, i_rst_n, 1'b1, r_cnt < w_period, "count out of period")
    // A status read leaves the interrupt cleared.
    `APUFS_ASSERT_NEXT(a_read_clears_irq, i_clk, i_rst_n, w_proc && r_in_mode == MODE_READ, !r_irq, "irq survived read")
    // Ticks in five-step mode never raise the interrupt.
    `APUFS_ASSERT_NEXT(a_five_no_irq, i_clk, i_rst_n, w_proc && r_in_mode == MODE_TICK && r_five && !r_irq, !r_irq, "irq in five-step mode")
    // A half-frame strobe always comes with a quarter-frame strobe.
    `APUFS_ASSERT_NOW(a_half_has_quarter, i_clk, i_rst_n, r_out_valid && r_out_data[9], r_out_data[8], "half without quarter")
    // A disabled channel holds a zero length.
    `APUFS_ASSERT_NOW(a_disabled_zero, i_clk, i_rst_n, 1'b1, !((!r_en[0] && r_len[0] != '0) || (!r_en[1] && r_len[1] != '0) || (!r_en[2] && r_len[2] != '0) || (!r_en[3] && r_len[3] != '0)), "disabled channel has length")

endmodule
